// ===== sv/particle_swarm_sphere_minimizer_assert.svh =====
// assertion macros for the swarm minimizer
// no dependencies
`ifndef PARTICLE_SWARM_SPHERE_MINIMIZER_ASSERT_SVH
`define PARTICLE_SWARM_SPHERE_MINIMIZER_ASSERT_SVH
// implication checked every clock, quiet in reset
`define PSM_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
// next-cycle implication
`define PSM_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// ===== sv/psm_pkg.sv =====
// shared types, constants and arithmetic for the swarm minimizer
// no dependencies
`default_nettype none
package psm_pkg;
  localparam int MaxParticles = 16;
  localparam logic signed [23:0] PosMax = 24'sh7fffff;
  localparam logic signed [23:0] PosMin = -24'sh800000;

  typedef enum logic [2:0] {
    REG_INERTIA = 3'd0, REG_PGAIN = 3'd1, REG_SGAIN = 3'd2,
    REG_ITER = 3'd3, REG_COUNT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
    logic signed [23:0] speed_x;
    logic signed [23:0] speed_y;
    logic last_particle;
  } in_item_t;

  typedef struct packed {
    logic [3:0] best_index;
    logic [31:0] best_fitness;
    logic signed [23:0] best_x;
    logic signed [23:0] best_y;
  } out_item_t;

  // gain term: floor((g*d + 2^13) / 2^14)
  function automatic logic signed [28:0] gain_term(input logic [15:0] g,
                                                   input logic signed [24:0] d);
    logic signed [42:0] p;
    begin
      p = $signed({1'b0, g}) * d + 43'sd8192;
      gain_term = p[42:14];
    end
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [30:0] v);
    begin
      if (v > 31'(PosMax)) sat24 = PosMax;
      else if (v < 31'(PosMin)) sat24 = PosMin;
      else sat24 = v[23:0];
    end
  endfunction

  // square of a 24 bit signed value
  function automatic logic [46:0] sq24(input logic signed [23:0] a);
    logic signed [47:0] p;
    begin
      p = a * a;
      sq24 = p[46:0];
    end
  endfunction

  // sum of two squares is at most 2^47, so the upper word always fits 32 bits
  function automatic logic [31:0] fit_of(input logic [46:0] a, input logic [46:0] b);
    logic [47:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      fit_of = s[47:16];
    end
  endfunction
endpackage
`default_nettype wire

// ===== sv/psm_ram.sv =====
// generic single write, single read ram with registered read
// no dependencies
`default_nettype none
module psm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(Depth)-1:0]  waddr,
  input  wire [Width-1:0]          wdata,
  input  wire [$clog2(Depth)-1:0]  raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/psm_update.sv =====
// per-particle velocity, position and fitness datapath, three register stages
// depends on psm_pkg
`default_nettype none
module psm_update (
  input  wire clk,
  input  wire [15:0] w,
  input  wire [15:0] c1,
  input  wire [15:0] c2,
  input  wire signed [23:0] x_in,
  input  wire signed [23:0] y_in,
  input  wire signed [23:0] vx_in,
  input  wire signed [23:0] vy_in,
  input  wire signed [23:0] px_in,
  input  wire signed [23:0] py_in,
  input  wire signed [23:0] gx_in,
  input  wire signed [23:0] gy_in,
  output logic signed [23:0] x_out,
  output logic signed [23:0] y_out,
  output logic signed [23:0] vx_out,
  output logic signed [23:0] vy_out,
  output logic [31:0] fit_out
);
  import psm_pkg::*;
  logic signed [28:0] tx0, tx1, tx2, ty0, ty1, ty2;
  logic signed [23:0] x1, y1, vx2, vy2, x2, y2;
  logic [46:0] sqx, sqy;

  // stage one: gain products
  always_ff @(posedge clk) begin
    tx0 <= gain_term(w, 25'(vx_in));
    tx1 <= gain_term(c1, 25'(px_in) - 25'(x_in));
    tx2 <= gain_term(c2, 25'(gx_in) - 25'(x_in));
    ty0 <= gain_term(w, 25'(vy_in));
    ty1 <= gain_term(c1, 25'(py_in) - 25'(y_in));
    ty2 <= gain_term(c2, 25'(gy_in) - 25'(y_in));
    x1 <= x_in;
    y1 <= y_in;
  end

  // stage two: velocity and position saturation
  always_comb begin
    vx2 = sat24(31'(tx0) + 31'(tx1) + 31'(tx2));
    vy2 = sat24(31'(ty0) + 31'(ty1) + 31'(ty2));
    x2 = sat24(31'(x1) + 31'(vx2));
    y2 = sat24(31'(y1) + 31'(vy2));
  end
  always_ff @(posedge clk) begin
    vx_out <= vx2;
    vy_out <= vy2;
    x_out <= x2;
    y_out <= y2;
  end

  // stage three: squares, then fitness
  assign sqx = sq24(x_out);
  assign sqy = sq24(y_out);
  always_ff @(posedge clk) begin
    fit_out <= fit_of(sqx, sqy);
  end
endmodule
`default_nettype wire

// ===== sv/particle_swarm_sphere_minimizer.sv =====
// swarm minimizer of x*x+y*y: loading one particle per beat, then an iterated run
// phases: a start pass reads each particle and writes its initial personal best, then each
// iteration reads, updates and writes back one particle at a time through the single update
// datapath and the shared read address of the state memories. one item at a time; output register frees input.
// reset clears state, config registers, counters, idx, gslot and out_valid; particle memories are undefined
`default_nettype none
module particle_swarm_sphere_minimizer
  import psm_pkg::*;
#(
  parameter int MAX_PARTICLES = MaxParticles
) (
  input  wire clk,
  input  wire rst,
  input  wire in_valid,
  output logic in_ready,
  input  wire psm_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire out_ready,
  output psm_pkg::out_item_t out_data,
  input  wire cfg_valid,
  output logic cfg_ready,
  input  wire [2:0] cfg_index,
  input  wire [15:0] cfg_data
);
  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int CW = AW + 1;

  typedef enum logic [3:0] {
    S_LOAD, S_INIT_RD, S_INIT_WT, S_INIT_FIT, S_IT_RD, S_IT_WT, S_IT_S1, S_IT_S2,
    S_IT_S3, S_IT_WB, S_OUT_RD, S_OUT_WT, S_DONE
  } st_t;
  st_t state;

  logic [15:0] w, c1, c2;
  logic [7:0] iter_lim, iter_cnt;
  logic [4:0] pcount;
  logic [CW-1:0] load_cnt, nuse;
  logic [AW-1:0] idx, gslot, cand_slot;
  logic [31:0] cand_fit;
  logic signed [23:0] gbx, gby, cbx, cby;

  // state memories: position+velocity, personal best position+fitness
  logic pv_we, pb_we;
  logic [AW-1:0] pv_waddr, pb_waddr, raddr;
  logic [95:0] pv_wdata, pv_rdata;
  logic [79:0] pb_wdata, pb_rdata;
  psm_ram #(.Width(96), .Depth(MAX_PARTICLES)) u_pv (.clk, .we(pv_we), .waddr(pv_waddr),
    .wdata(pv_wdata), .raddr, .rdata(pv_rdata));
  psm_ram #(.Width(80), .Depth(MAX_PARTICLES)) u_pb (.clk, .we(pb_we), .waddr(pb_waddr),
    .wdata(pb_wdata), .raddr, .rdata(pb_rdata));

  logic [95:0] pv_q;
  logic [79:0] pb_q;
  logic signed [23:0] ux, uy, uvx, uvy;
  logic [31:0] ufit;
  psm_update u_upd (.clk, .w, .c1, .c2,
    .x_in(pv_q[95:72]), .y_in(pv_q[71:48]), .vx_in(pv_q[47:24]), .vy_in(pv_q[23:0]),
    .px_in(pb_q[79:56]), .py_in(pb_q[55:32]), .gx_in(gbx), .gy_in(gby),
    .x_out(ux), .y_out(uy), .vx_out(uvx), .vy_out(uvy), .fit_out(ufit));

  logic [31:0] init_fit;
  logic [46:0] isx, isy;
  assign isx = sq24(pv_q[95:72]);
  assign isy = sq24(pv_q[71:48]);

  logic in_acc, better, last_idx;
  logic [31:0] new_pfit;
  logic signed [23:0] new_px, new_py;
  assign in_acc = in_valid && in_ready;
  assign in_ready = (state == S_LOAD);
  assign cfg_ready = 1'b1;
  assign last_idx = (CW'(idx) == nuse - CW'(1));
  assign better = ufit < pb_q[31:0];
  assign new_pfit = better ? ufit : pb_q[31:0];
  assign new_px = better ? ux : pb_q[79:56];
  assign new_py = better ? uy : pb_q[55:32];

  // memory port control
  always_comb begin
    pv_we = 1'b0;
    pb_we = 1'b0;
    pv_waddr = idx;
    pb_waddr = idx;
    pv_wdata = {ux, uy, uvx, uvy};
    pb_wdata = {new_px, new_py, new_pfit};
    raddr = idx;
    if (state == S_LOAD) begin
      pv_waddr = load_cnt[AW-1:0];
      pv_wdata = {in_data.start_x, in_data.start_y, in_data.speed_x, in_data.speed_y};
      pv_we = in_acc && (load_cnt < CW'(MAX_PARTICLES));
    end else if (state == S_INIT_FIT) begin
      pb_we = 1'b1;
      pb_wdata = {pv_q[95:72], pv_q[71:48], init_fit};
    end else if (state == S_IT_WB) begin
      pv_we = 1'b1;
      pb_we = 1'b1;
    end else if (state == S_OUT_RD || state == S_OUT_WT || state == S_DONE) begin
      raddr = gslot;
    end
  end
  assign init_fit = fit_of(isx, isy);

  // control sequencer and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      w <= 16'd8192;
      c1 <= 16'd8192;
      c2 <= 16'd8192;
      iter_lim <= 8'd50;
      pcount <= 5'd10;
      load_cnt <= '0;
      iter_cnt <= '0;
      gslot <= '0;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_INERTIA: w <= cfg_data;
          REG_PGAIN: c1 <= cfg_data;
          REG_SGAIN: c2 <= cfg_data;
          REG_ITER: iter_lim <= cfg_data[7:0];
          REG_COUNT: pcount <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (load_cnt < CW'(MAX_PARTICLES)) load_cnt <= load_cnt + CW'(1);
            if (in_data.last_particle) begin
              if (pcount == 5'd0) nuse <= CW'(1);
              else if (32'(pcount) > MAX_PARTICLES) nuse <= CW'(MAX_PARTICLES);
              else nuse <= CW'(pcount);
              idx <= '0;
              iter_cnt <= '0;
              state <= S_INIT_RD;
            end
          end
        end
        S_INIT_RD: state <= S_INIT_WT;
        S_INIT_WT: begin
          pv_q <= pv_rdata;
          state <= S_INIT_FIT;
        end
        S_INIT_FIT: begin
          if (idx == '0 || init_fit < cand_fit) begin
            cand_fit <= init_fit;
            cand_slot <= idx;
            cbx <= pv_q[95:72];
            cby <= pv_q[71:48];
          end
          if (last_idx) begin
            idx <= '0;
            state <= S_IT_RD;
          end else begin
            idx <= idx + AW'(1);
            state <= S_INIT_RD;
          end
        end
        S_IT_RD: begin
          // latch global best of the previous pass at iteration start
          if (idx == '0) begin
            gslot <= cand_slot;
            gbx <= cbx;
            gby <= cby;
            if (iter_cnt == iter_lim) state <= S_OUT_RD;
            else state <= S_IT_WT;
          end else begin
            state <= S_IT_WT;
          end
        end
        S_IT_WT: begin
          pv_q <= pv_rdata;
          pb_q <= pb_rdata;
          state <= S_IT_S1;
        end
        S_IT_S1: state <= S_IT_S2;
        S_IT_S2: state <= S_IT_S3;
        S_IT_S3: state <= S_IT_WB;
        S_IT_WB: begin
          if (idx == '0 || new_pfit < cand_fit) begin
            cand_fit <= new_pfit;
            cand_slot <= idx;
            cbx <= new_px;
            cby <= new_py;
          end
          if (last_idx) begin
            idx <= '0;
            iter_cnt <= iter_cnt + 8'd1;
          end else begin
            idx <= idx + AW'(1);
          end
          state <= S_IT_RD;
        end
        S_OUT_RD: state <= S_OUT_WT;
        S_OUT_WT: state <= S_DONE;
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data.best_index <= 4'(gslot);
            out_data.best_fitness <= pb_rdata[31:0];
            out_data.best_x <= pb_rdata[79:56];
            out_data.best_y <= pb_rdata[55:32];
            load_cnt <= '0;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `include "particle_swarm_sphere_minimizer_assert.svh"
  `PSM_ASSERT_IMP(a_no_load_busy, in_ready, state == S_LOAD)
  `PSM_ASSERT_IMP(a_idx_range, state == S_IT_WB, CW'(idx) < nuse)
  `PSM_ASSERT_NXT(a_out_holds, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire
